>>> sv/mbss_pkg.sv
`timescale 1ns / 1ps

package mbss_pkg;

    // Default window depth in bytes
    localparam int MAX_PATTERN_BYTES = 32;

    // Bytes in the relative word
    localparam int REL_WORD_BYTES = 4;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_PAT_0_7   = 3'd0,
        REG_PAT_8_15  = 3'd1,
        REG_PAT_16_23 = 3'd2,
        REG_PAT_24_31 = 3'd3,
        REG_CARE_MASK = 3'd4,
        REG_PAT_LEN   = 3'd5,
        REG_SKIP      = 3'd6,
        REG_REL_SEL   = 3'd7
    } cfg_reg_t;

    // Settings derived from the configuration registers, used per word
    typedef struct packed {
        logic        rel;   // relative mode
        logic [63:0] adj;   // added to the newest-byte address
        logic [15:0] skip;  // matches to pass over
    } cfg_ctrl_t;

    // Flags of the word held in the window stage
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } win_stat_t;

endpackage

>>> sv/mbss_cfg.sv
`timescale 1ns / 1ps

module mbss_cfg #(
    parameter int MAX_PATTERN_BYTES = mbss_pkg::MAX_PATTERN_BYTES
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [2:0]                             cfg_index,
    input  logic [63:0]                            cfg_data,
    output logic [MAX_PATTERN_BYTES-1:0][7:0]      apat,
    output logic [MAX_PATTERN_BYTES-1:0]           acare,
    output logic [$clog2(MAX_PATTERN_BYTES+1)-1:0] w_len,
    output logic [$clog2(MAX_PATTERN_BYTES)-1:0]   wbase,
    output mbss_pkg::cfg_ctrl_t                    ctrl
);

    localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W = $clog2(MAX_PATTERN_BYTES);

    logic [3:0][63:0] pat_reg;
    logic [31:0]      mask_reg;
    logic [5:0]       len_reg;
    logic [15:0]      skip_reg;
    logic [4:0]       rel_reg;

    logic [MAX_PATTERN_BYTES-1:0][7:0] apat_reg, apat_next;
    logic [MAX_PATTERN_BYTES-1:0]      acare_reg, acare_next;
    logic [CNT_W-1:0]                  w_reg, w_next;
    logic [IDX_W-1:0]                  wbase_reg, wbase_next;
    mbss_pkg::cfg_ctrl_t               ctrl_reg, ctrl_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg  <= '0;
            mask_reg <= '0;
            len_reg  <= 6'd1;
            skip_reg <= '0;
            rel_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mbss_pkg::REG_PAT_0_7:   pat_reg[0] <= cfg_data;
                mbss_pkg::REG_PAT_8_15:  pat_reg[1] <= cfg_data;
                mbss_pkg::REG_PAT_16_23: pat_reg[2] <= cfg_data;
                mbss_pkg::REG_PAT_24_31: pat_reg[3] <= cfg_data;
                mbss_pkg::REG_CARE_MASK: mask_reg   <= cfg_data[31:0];
                mbss_pkg::REG_PAT_LEN:   len_reg    <= cfg_data[5:0];
                mbss_pkg::REG_SKIP:      skip_reg   <= cfg_data[15:0];
                mbss_pkg::REG_REL_SEL:   rel_reg    <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Align pattern and care bits to window slots (slot 0 holds the newest byte)
    always_comb
    begin
        int         len_i;
        int         off_i;
        int         w_i;
        int         pos_i;
        logic [4:0] pidx;
        logic [255:0] pat_flat;

        pat_flat = pat_reg;
        len_i = int'(len_reg);
        if (len_i == 0)
            len_i = 1;
        if (len_i > MAX_PATTERN_BYTES)
            len_i = MAX_PATTERN_BYTES;
        w_i   = len_i;
        off_i = 0;
        if (rel_reg != 5'd0)
        begin
            off_i = int'(rel_reg) - 1;
            if (off_i > MAX_PATTERN_BYTES - mbss_pkg::REL_WORD_BYTES)
                off_i = MAX_PATTERN_BYTES - mbss_pkg::REL_WORD_BYTES;
            if (off_i + mbss_pkg::REL_WORD_BYTES > w_i)
                w_i = off_i + mbss_pkg::REL_WORD_BYTES;
        end

        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        begin
            pos_i = w_i - 1 - j;
            pidx  = pos_i[4:0];
            if (j < w_i && pos_i < 32 && pos_i < len_i)
            begin
                apat_next[j]  = pat_flat[8*pidx +: 8];
                acare_next[j] = mask_reg[pidx];
            end
            else
            begin
                apat_next[j]  = 8'h00;
                acare_next[j] = 1'b0;
            end
        end

        w_next          = CNT_W'(w_i);
        ctrl_next.rel   = (rel_reg != 5'd0);
        ctrl_next.skip  = skip_reg;
        if (rel_reg != 5'd0)
        begin
            wbase_next    = IDX_W'(w_i - mbss_pkg::REL_WORD_BYTES - off_i);
            ctrl_next.adj = 64'(off_i + mbss_pkg::REL_WORD_BYTES + 1 - w_i);
        end
        else
        begin
            wbase_next    = '0;
            ctrl_next.adj = 64'(1 - w_i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apat_reg  <= '0;
            acare_reg <= '0;
            w_reg     <= CNT_W'(1);
            wbase_reg <= '0;
            ctrl_reg  <= '0;
        end
        else
        begin
            apat_reg  <= apat_next;
            acare_reg <= acare_next;
            w_reg     <= w_next;
            wbase_reg <= wbase_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    assign apat  = apat_reg;
    assign acare = acare_reg;
    assign w_len = w_reg;
    assign wbase = wbase_reg;
    assign ctrl  = ctrl_reg;

endmodule

>>> sv/mbss_win.sv
`timescale 1ns / 1ps

module mbss_win #(
    parameter int MAX_PATTERN_BYTES = mbss_pkg::MAX_PATTERN_BYTES
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [7:0]                             data_byte,
    input  logic                                   first_byte,
    input  logic                                   last_byte,
    input  logic [63:0]                            base_address,
    input  logic                                   adv,
    output logic [MAX_PATTERN_BYTES-1:0][7:0]      window,
    output logic [63:0]                            cur_addr,
    output logic [$clog2(MAX_PATTERN_BYTES+1)-1:0] seen,
    output mbss_pkg::win_stat_t                    stat
);

    localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1);

    logic [MAX_PATTERN_BYTES-1:0][7:0] window_reg;
    logic [63:0]                       addr_reg;
    logic [CNT_W-1:0]                  seen_reg, seen_next;
    mbss_pkg::win_stat_t               stat_reg;
    logic                              accept;

    // Take a word when the stage is empty or drains this cycle
    assign in_ready = !stat_reg.valid || adv;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (first_byte)
            seen_next = CNT_W'(1);
        else if (seen_reg < CNT_W'(MAX_PATTERN_BYTES))
            seen_next = seen_reg + CNT_W'(1);
        else
            seen_next = seen_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            addr_reg   <= '0;
            seen_reg   <= '0;
            stat_reg   <= '0;
        end
        else if (accept)
        begin
            window_reg     <= {window_reg[MAX_PATTERN_BYTES-2:0], data_byte};
            addr_reg       <= first_byte ? base_address : addr_reg + 64'd1;
            seen_reg       <= seen_next;
            stat_reg.valid <= 1'b1;
            stat_reg.first <= first_byte;
            stat_reg.last  <= last_byte;
        end
        else if (adv)
        begin
            stat_reg.valid <= 1'b0;
        end
    end

    assign window   = window_reg;
    assign cur_addr = addr_reg;
    assign seen     = seen_reg;
    assign stat     = stat_reg;

endmodule

>>> sv/mbss_eval.sv
`timescale 1ns / 1ps

module mbss_eval #(
    parameter int MAX_PATTERN_BYTES = mbss_pkg::MAX_PATTERN_BYTES
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [MAX_PATTERN_BYTES-1:0][7:0]      window,
    input  logic [63:0]                            cur_addr,
    input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0] seen,
    input  mbss_pkg::win_stat_t                    stat,
    input  logic [MAX_PATTERN_BYTES-1:0][7:0]      apat,
    input  logic [MAX_PATTERN_BYTES-1:0]           acare,
    input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0] w_len,
    input  logic [$clog2(MAX_PATTERN_BYTES)-1:0]   wbase,
    input  mbss_pkg::cfg_ctrl_t                    ctrl,
    output logic                                   adv,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   found,
    output logic [63:0]                            address
);

    localparam int IDX_W = $clog2(MAX_PATTERN_BYTES);

    logic        hit_done_reg, hit_done_next;
    logic [15:0] matches_reg, matches_next;
    logic        out_valid_reg, out_valid_next;
    logic        found_reg, found_next;
    logic [63:0] addr_reg, addr_next;

    logic        match;
    logic [31:0] word;
    logic [63:0] target;

    assign adv = !out_valid_reg || out_ready;

    always_comb
    begin
        logic [IDX_W-1:0] widx;

        match = 1'b1;
        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        begin
            if (acare[j] && window[j] != apat[j])
                match = 1'b0;
        end

        // Byte k of the word sits k slots newer than the oldest word byte
        for (int k = 0; k < mbss_pkg::REL_WORD_BYTES; k++)
        begin
            widx = IDX_W'(int'(wbase) + mbss_pkg::REL_WORD_BYTES - 1 - k);
            word[8*k +: 8] = ctrl.rel ? window[widx] : 8'h00;
        end

        target = cur_addr + ctrl.adj + {32'd0, word};
    end

    always_comb
    begin
        logic        done_eff;
        logic [15:0] passed_eff;

        done_eff       = stat.first ? 1'b0 : hit_done_reg;
        passed_eff     = stat.first ? 16'd0 : matches_reg;
        hit_done_next  = hit_done_reg;
        matches_next   = matches_reg;
        out_valid_next = 1'b0;
        found_next     = found_reg;
        addr_next      = addr_reg;

        if (stat.valid)
        begin
            hit_done_next = done_eff;
            matches_next  = passed_eff;
            if (!done_eff)
            begin
                if (seen >= w_len && match && passed_eff == ctrl.skip)
                begin
                    hit_done_next  = 1'b1;
                    out_valid_next = 1'b1;
                    found_next     = 1'b1;
                    addr_next      = target;
                end
                else
                begin
                    if (seen >= w_len && match)
                        matches_next = passed_eff + 16'd1;
                    if (stat.last)
                    begin
                        hit_done_next  = 1'b1;
                        out_valid_next = 1'b1;
                        found_next     = 1'b0;
                        addr_next      = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_done_reg  <= 1'b0;
            matches_reg   <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            addr_reg      <= '0;
        end
        else if (adv)
        begin
            hit_done_reg  <= hit_done_next;
            matches_reg   <= matches_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            addr_reg      <= addr_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign address   = addr_reg;

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> addr_reg == 64'd0)
        else $error("not-found result carries a nonzero address");

    a_one_per_region: assert property (@(posedge clk) disable iff (!rst_n)
        stat.valid && !stat.first && hit_done_reg && adv |=> !out_valid_reg)
        else $error("second result in one region");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(stat.valid))
        else $error("result without a word in the window stage");

endmodule

>>> sv/masked_byte_signature_scan_core.sv
`timescale 1ns / 1ps
// Path: window register, then the result register of the evaluation stage.
// Throughput: one byte per cycle unless a result waits on m_tready; slots compare in parallel.
// A configuration write applies after its register and then the derived settings register.
// Reset (rst_n low, asynchronous): window, counters and registers clear,
// pattern_length returns to 1; no result is pending.

module masked_byte_signature_scan_core #(
    parameter int MAX_PATTERN_BYTES = mbss_pkg::MAX_PATTERN_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // data_byte [7:0], base_address [71:8]
    input  logic        s_tuser,   // first_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // address [63:0]
    output logic        m_tuser,   // found
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W = $clog2(MAX_PATTERN_BYTES);

    logic [MAX_PATTERN_BYTES-1:0][7:0] apat;
    logic [MAX_PATTERN_BYTES-1:0]      acare;
    logic [CNT_W-1:0]                  w_len;
    logic [IDX_W-1:0]                  wbase;
    mbss_pkg::cfg_ctrl_t               ctrl;

    logic [MAX_PATTERN_BYTES-1:0][7:0] window;
    logic [63:0]                       cur_addr;
    logic [CNT_W-1:0]                  seen;
    mbss_pkg::win_stat_t               stat;
    logic                              adv;

    mbss_cfg #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .apat     (apat),
        .acare    (acare),
        .w_len    (w_len),
        .wbase    (wbase),
        .ctrl     (ctrl)
    );

    mbss_win #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_win (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .data_byte   (s_tdata[7:0]),
        .first_byte  (s_tuser),
        .last_byte   (s_tlast),
        .base_address(s_tdata[71:8]),
        .adv         (adv),
        .window      (window),
        .cur_addr    (cur_addr),
        .seen        (seen),
        .stat        (stat)
    );

    mbss_eval #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .window   (window),
        .cur_addr (cur_addr),
        .seen     (seen),
        .stat     (stat),
        .apat     (apat),
        .acare    (acare),
        .w_len    (w_len),
        .wbase    (wbase),
        .ctrl     (ctrl),
        .adv      (adv),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .found    (m_tuser),
        .address  (m_tdata)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int NB            = mbss_pkg::MAX_PATTERN_BYTES;
    localparam int ITEMS         = 1500;
    localparam int PHASE_ITEMS   = 80;
    localparam int RX_HOLD       = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 4;

    class hit_tracker;
        typedef struct {
            bit          found;
            logic [63:0] address;
        } report_t;

        report_t     pending[$];
        logic [63:0] pat_regs[4];
        logic [31:0] care;
        logic [5:0]  plen;
        logic [15:0] skip;
        logic [4:0]  rsel;
        logic [7:0]  win[NB];
        int          seen;
        logic [63:0] cur_addr;
        logic [15:0] passed;
        bit          done;
        int          errors;

        function new();
            foreach (pat_regs[i]) pat_regs[i] = '0;
            foreach (win[i]) win[i] = '0;
            care     = '0;
            plen     = 6'd1;
            skip     = '0;
            rsel     = '0;
            seen     = 0;
            cur_addr = '0;
            passed   = '0;
            done     = 1'b0;
            errors   = 0;
        endfunction

        function void set_reg(mbss_pkg::cfg_reg_t idx, logic [63:0] v);
            case (idx)
                mbss_pkg::REG_PAT_0_7, mbss_pkg::REG_PAT_8_15,
                mbss_pkg::REG_PAT_16_23, mbss_pkg::REG_PAT_24_31:
                    pat_regs[int'(idx)] = v;
                mbss_pkg::REG_CARE_MASK: care = v[31:0];
                mbss_pkg::REG_PAT_LEN:   plen = v[5:0];
                mbss_pkg::REG_SKIP:      skip = v[15:0];
                mbss_pkg::REG_REL_SEL:   rsel = v[4:0];
                default: ;
            endcase
        endfunction

        // Returns 1 when the byte was scanned, 0 when the region was already reported.
        function bit take_byte(logic [7:0] b, bit is_first, bit is_last, logic [63:0] base);
            int          len;
            int          off;
            int          w;
            bit          hit;
            logic [63:0] start;
            logic [63:0] word;
            if (is_first)
            begin
                cur_addr = base;
                seen     = 0;
                passed   = '0;
                done     = 1'b0;
            end
            else
                cur_addr = cur_addr + 64'd1;
            for (int i = NB - 1; i > 0; i--)
                win[i] = win[i - 1];
            win[0] = b;
            if (seen < NB)
                seen++;
            if (done)
                return 1'b0;

            len = (plen == 0) ? 1 : ((plen > NB) ? NB : int'(plen));
            w   = len;
            off = 0;
            if (rsel != 0)
            begin
                off = int'(rsel) - 1;
                if (off > NB - 4)
                    off = NB - 4;
                if (off + 4 > w)
                    w = off + 4;
            end

            if (seen >= w)
            begin
                hit = 1'b1;
                for (int i = 0; i < w; i++)
                    if (i < len && i < 32 && care[i] &&
                        win[w - 1 - i] != pat_regs[i >> 3][(i & 7) * 8 +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    if (passed == skip)
                    begin
                        start = cur_addr - 64'(w - 1);
                        if (rsel != 0)
                        begin
                            // little-endian word at byte off of the window
                            word  = {32'd0, win[w - 4 - off], win[w - 3 - off],
                                     win[w - 2 - off], win[w - 1 - off]};
                            start = start + 64'(off) + 64'd4 + word;
                        end
                        done = 1'b1;
                        pending.push_back('{1'b1, start});
                        return 1'b1;
                    end
                    passed = passed + 16'd1;
                end
            end

            if (is_last)
            begin
                done = 1'b1;
                pending.push_back('{1'b0, 64'd0});
            end
            return 1'b1;
        endfunction

        function void check_report(bit found, logic [63:0] address);
            report_t exp_rep;
            if (pending.size() == 0)
            begin
                $error("unexpected result: found %0b address %h", found, address);
                errors++;
                return;
            end
            exp_rep = pending.pop_front();
            if (found !== exp_rep.found)
            begin
                $error("found: expected %0b, got %0b", exp_rep.found, found);
                errors++;
            end
            if (address !== exp_rep.address)
            begin
                $error("address: expected %h, got %h", exp_rep.address, address);
                errors++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;   // data_byte [7:0], base_address [71:8]
    logic        s_tuser   = 1'b0; // first_byte
    logic        s_tlast   = 1'b0; // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;          // address [63:0]
    logic        m_tuser;          // found
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    hit_tracker  tracker = new();

    logic [63:0] cfg_val[8];
    logic [7:0]  cur_pat[32];
    int          eff_len     = 1;
    int          scanned     = 0;
    int          quiet_count = 0;
    bit          no_gaps     = 1'b0;
    bit          stall_rx    = 1'b0;

    masked_byte_signature_scan_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Result side: check each accepted word, then pick the next ready level.
    initial
    begin : rx_side
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                tracker.check_report(m_tuser, m_tdata);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_rx)
            begin
                stall_rx  = 1'b0;
                hold_left = RX_HOLD;
                m_tready <= 1'b0;
            end
            else
                m_tready <= no_gaps || ($urandom_range(0, 99) >= 11);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_count <= 0;
            else
                quiet_count <= quiet_count + 1;
            if (quiet_count >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Leaves tvalid high so that the next word can follow without a gap.
    task automatic send_byte(logic [7:0] b, bit is_first, bit is_last, logic [63:0] base);
        if (!no_gaps)
            while ($urandom_range(0, 99) < 11)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= {base, b};
        s_tuser  <= is_first;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        void'(tracker.take_byte(b, is_first, is_last, base));
        scanned++;
    endtask

    task automatic send_seq(logic [7:0] seq[$], logic [63:0] base);
        for (int i = 0; i < seq.size(); i++)
            send_byte(seq[i], i == 0, i == seq.size() - 1, base);
    endtask

    task automatic write_reg(mbss_pkg::cfg_reg_t idx, logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_reg(idx, v);
    endtask

    task automatic load_settings();
        for (int i = 0; i < 8; i++)
            write_reg(mbss_pkg::cfg_reg_t'(i), cfg_val[i]);
        cfg_valid <= 1'b0;
        for (int k = 0; k < 32; k++)
            cur_pat[k] = cfg_val[k >> 3][(k & 7) * 8 +: 8];
        eff_len = (cfg_val[mbss_pkg::REG_PAT_LEN][5:0] == 0) ? 1 :
                  ((cfg_val[mbss_pkg::REG_PAT_LEN][5:0] > NB) ? NB :
                   int'(cfg_val[mbss_pkg::REG_PAT_LEN][5:0]));
    endtask

    // Stop offering, drain every pending result, and let the pipeline empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic choose_settings(int p);
        int          plen_ext[5] = '{0, 32, 63, 33, 1};
        int          rel_ext[5]  = '{31, 0, 30, 29, 1};
        int          skip_ext[5] = '{0, 65535, 0, 1, 2};
        int          plen_v;
        int          rel_v;
        int          skip_v;
        int          r;
        logic [31:0] care_v;
        for (int i = 0; i < 4; i++)
            cfg_val[i] = (p == 0) ? '1 : ((p == 1) ? '0 : {$urandom, $urandom});
        r = $urandom_range(0, 9);
        care_v = (p == 0 || r == 0) ? '1 : ((p == 1 || r == 1) ? '0 : $urandom);
        if (p < 5)
        begin
            plen_v = plen_ext[p];
            rel_v  = rel_ext[p];
            skip_v = skip_ext[p];
        end
        else
        begin
            plen_v = ($urandom_range(0, 9) < 2) ? plen_ext[$urandom_range(0, 4)] :
                                                  $urandom_range(1, 8);
            rel_v  = $urandom_range(0, 1) ? 0 : $urandom_range(1, 31);
            r = $urandom_range(0, 19);
            skip_v = (r < 11) ? 0 : ((r < 16) ? $urandom_range(1, 3) :
                     ((r < 19) ? $urandom_range(4, 20) : 65535));
        end
        // fill the unused upper bits with noise
        cfg_val[mbss_pkg::REG_CARE_MASK]      = {$urandom, care_v};
        cfg_val[mbss_pkg::REG_PAT_LEN]        = {$urandom, $urandom};
        cfg_val[mbss_pkg::REG_PAT_LEN][5:0]   = plen_v[5:0];
        cfg_val[mbss_pkg::REG_SKIP]           = {$urandom, $urandom};
        cfg_val[mbss_pkg::REG_SKIP][15:0]     = skip_v[15:0];
        cfg_val[mbss_pkg::REG_REL_SEL]        = {$urandom, $urandom};
        cfg_val[mbss_pkg::REG_REL_SEL][4:0]   = rel_v[4:0];
    endtask

    // A region of random bytes, often with copies of the pattern planted in it.
    task automatic send_region();
        logic [7:0]  body[128];
        logic [63:0] base;
        int          n;
        int          style;
        int          pos;
        int          r;
        bit          has_first;
        bit          has_last;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 128) :
                                           $urandom_range(1, eff_len + 32);
        style = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            body[i] = (style == 2) ? cur_pat[$urandom_range(0, eff_len - 1)] :
                                     8'($urandom);
        if (style != 0)
            repeat ($urandom_range(1, 3))
            begin
                pos = $urandom_range(0, n - 1);
                for (int k = 0; k < eff_len && pos + k < n; k++)
                    if (cfg_val[mbss_pkg::REG_CARE_MASK][k] || $urandom_range(0, 1))
                        body[pos + k] = cur_pat[k];
            end
        r = $urandom_range(0, 9);
        base = (r == 0) ? '0 : ((r == 1) ? ('1 - 64'($urandom_range(0, 40))) :
                                           {$urandom, $urandom});
        has_first = $urandom_range(0, 99) >= 5;
        has_last  = $urandom_range(0, 99) >= 10;
        for (int i = 0; i < n; i++)
            send_byte(body[i],
                      (i == 0 && has_first) || ($urandom_range(0, 99) < 2),
                      (i == n - 1 && has_last) || ($urandom_range(0, 99) < 2),
                      (i == 0) ? base : {$urandom, $urandom});
    endtask

    initial
    begin : stimulus
        int p;
        int mark;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes ahead of any region start, under the reset settings
        send_byte(8'h00, 1'b0, 1'b0, '1);
        send_byte(8'hFF, 1'b0, 1'b0, '0);
        settle();

        cfg_val = '{64'hEFBE_ADDE, '0, '0, '0, 64'hF, 64'd4, 64'd0, 64'd0};
        load_settings();
        // hit on the final byte, with the start address wrapping past zero
        send_seq('{8'h11, 8'hDE, 8'hAD, 8'hBE, 8'hEF}, '1);
        send_seq('{8'h00, 8'hFF, 8'hFF}, '0);
        // hit mid-region; the trailing bytes give nothing
        send_seq('{8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h00, 8'hFF}, 64'h100);
        settle();

        // relative mode: word at byte 2 of a six-byte window
        cfg_val = '{64'h8B48, '0, '0, '0, 64'h3, 64'd2, 64'd0, 64'd3};
        load_settings();
        send_seq('{8'h48, 8'h8B, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 64'h1000);
        settle();

        p = 0;
        while (scanned < ITEMS)
        begin
            choose_settings(p);
            load_settings();
            no_gaps = (p == 2);
            if (p == 3)
                stall_rx = 1'b1;
            mark = scanned;
            while (scanned - mark < PHASE_ITEMS)
                send_region();
            settle();
            p++;
        end

        if (tracker.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
